// ===== rtl/core/srw_pkg.sv =====
// Shared types, codes and constants of the selective repeat receive window.
package srw_pkg;

  localparam int SEQ_W      = 16;
  localparam int SEQ_BITS   = 16;
  localparam int RANGE_W    = 17;
  localparam int WIN_W      = 5;
  localparam int MAX_WALK   = 16;
  localparam int DIV_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int SLOT_OUT_W = 4;

  localparam logic [32:0] SEQ_MAX = 33'd1 << SEQ_BITS;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS  = 2'd2;

  typedef enum logic [1:0] {
    KIND_ACCEPT  = 2'd0,
    KIND_DUP     = 2'd1,
    KIND_OOW     = 2'd2,
    KIND_DELIVER = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    DIV_BASE,
    DIV_OFF,
    DIV_SLOT,
    DIV_CUR,
    DIV_RS
  } div_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE,
    S_CHECK,
    S_OFF,
    S_SLOT,
    S_ACCEPT,
    S_CUR,
    S_RS,
    S_WALK
  } state_e;

  typedef struct packed {
    logic     load_seq;
    logic     div_start;
    div_sel_e div_sel;
    logic     emit_verdict;
    logic     emit_accept;
    logic     walk_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic reject;
    logic is_base;
    logic walk_cont;
  } dp_stat_t;

endpackage

// ===== rtl/core/srw_div.sv =====
// Shift-subtract remainder unit, one dividend bit per cycle.
module srw_div #(
  parameter int W = 17
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] rem_o
);

  localparam int CNT_W = $clog2(W + 1);
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(W);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     dvd_q;
  logic [W-1:0]     dsr_q;
  logic [W:0]       rem_sh;

  always_comb begin
    rem_sh = {rem_q, dvd_q[W-1]};
    if (rem_sh >= {1'b0, dsr_q}) begin
      rem_d = W'(rem_sh - {1'b0, dsr_q});
    end else begin
      rem_d = W'(rem_sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_ONE) && !start_i;
      if (start_i) begin
        cnt_q <= CNT_INIT;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      dvd_q <= dvd_q << 1;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/srw_ctrl.sv =====
// Controller state machine sequencing the verdict, slot choice and delivery walk.
module srw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  srw_pkg::dp_stat_t  stat_i,
  output srw_pkg::ctrl_cmd_t cmd_o,
  output logic               busy_o
);

  import srw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_seq  = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_BASE;
          state_d         = S_BASE;
        end
      end
      S_BASE: begin
        if (stat_i.div_done) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.reject) begin
          cmd_o.emit_verdict = 1'b1;
          state_d            = S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_OFF;
          state_d         = S_OFF;
        end
      end
      S_OFF: begin
        if (stat_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_SLOT;
          state_d         = S_SLOT;
        end
      end
      S_SLOT: begin
        if (stat_i.div_done) state_d = S_ACCEPT;
      end
      S_ACCEPT: begin
        cmd_o.emit_accept = 1'b1;
        if (stat_i.is_base) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_CUR;
          state_d         = S_CUR;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CUR: begin
        if (stat_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_RS;
          state_d         = S_RS;
        end
      end
      S_RS: begin
        if (stat_i.div_done) state_d = S_WALK;
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (!stat_i.walk_cont) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== rtl/core/srw_dp.sv =====
// Datapath: configuration, window state, received marks, remainder unit and result registers.
module srw_dp #(
  parameter int BUF_SLOTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  srw_pkg::ctrl_cmd_t                cmd_i,
  output srw_pkg::dp_stat_t                 stat_o,
  input  logic [srw_pkg::SEQ_W-1:0]         seq_number_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [srw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [srw_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                              result_strobe_o,
  output logic [1:0]                        kind_o,
  output logic [srw_pkg::SLOT_OUT_W-1:0]    slot_o,
  output logic [srw_pkg::SEQ_W-1:0]         delivered_seq_o,
  output logic                              ack_req_o,
  output logic                              last_o
);

  import srw_pkg::*;

  localparam int SW = $clog2(BUF_SLOTS);
  localparam int CW = $clog2(BUF_SLOTS + 1);

  // configuration
  logic [WIN_W-1:0]   win_q;
  logic [RANGE_W-1:0] range_cfg_q;
  logic [WIN_W-1:0]   slots_cfg_q;

  logic [CW-1:0]      slots_eff;
  logic [RANGE_W-1:0] range_eff;
  logic [WIN_W-1:0]   n_eff;
  logic [RANGE_W-1:0] n_tmp;

  // window state
  logic [BUF_SLOTS-1:0] marks_q;
  logic [SEQ_W-1:0]     window_base_q;
  logic [SW-1:0]        offc_q;
  logic [SW-1:0]        offp_q;

  // per-item working registers
  logic [SEQ_W-1:0] seq_q;
  logic [SEQ_W-1:0] base_q;
  logic [SW-1:0]    slot_idx_q;
  logic [SW-1:0]    cur_q;
  logic [SW-1:0]    rs_q;
  logic [SW-1:0]    i_q;
  logic [WIN_W-1:0] walked_q;
  logic             pend_v_q;
  logic [SW-1:0]    pend_slot_q;
  logic [SEQ_W-1:0] pend_seq_q;
  div_sel_e         sel_q;

  // result registers
  logic                  strobe_q;
  logic [1:0]            kind_q;
  logic [SLOT_OUT_W-1:0] slot_out_q;
  logic [SEQ_W-1:0]      dseq_q;
  logic                  ack_q;
  logic                  last_q;

  // remainder unit
  logic             div_done;
  logic [DIV_W-1:0] div_rem;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;

  // verdict
  logic             seq_oor;
  logic [17:0]      d_sum;
  logic [17:0]      d_val;
  logic             d_ge_n;
  logic             dup;
  logic             wraps;
  logic             is_base;
  logic [SW-1:0]    off_sel;

  // walk
  logic             walk_cont;
  logic [16:0]      nb_full;
  logic [SEQ_W-1:0] next_base;
  logic [17:0]      end_new;
  logic             end_zero;
  logic [SW:0]      newc_sum;
  logic [SW-1:0]    newc;
  logic [SW:0]      ip1;
  logic [SW-1:0]    i_next;

  logic emit_any;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (slots_cfg_q == '0) begin
      slots_eff = CW'(1);
    end else if (32'(slots_cfg_q) > 32'(BUF_SLOTS)) begin
      slots_eff = CW'(BUF_SLOTS);
    end else begin
      slots_eff = CW'(slots_cfg_q);
    end

    if (range_cfg_q < RANGE_W'(2)) begin
      range_eff = RANGE_W'(2);
    end else if (33'(range_cfg_q) > SEQ_MAX) begin
      range_eff = RANGE_W'(SEQ_MAX);
    end else begin
      range_eff = range_cfg_q;
    end

    n_tmp = (win_q == '0) ? RANGE_W'(1) : RANGE_W'(win_q);
    if (n_tmp > RANGE_W'(slots_eff)) n_tmp = RANGE_W'(slots_eff);
    if (n_tmp > range_eff) n_tmp = range_eff;
    if (n_tmp > RANGE_W'(MAX_WALK)) n_tmp = RANGE_W'(MAX_WALK);
    n_eff = WIN_W'(n_tmp);
  end

  always_comb begin
    seq_oor = ({1'b0, seq_q} >= range_eff);
    d_sum   = 18'(seq_q) + 18'(range_eff) - 18'(base_q);
    d_val   = (d_sum >= 18'(range_eff)) ? (d_sum - 18'(range_eff)) : d_sum;
    d_ge_n  = (d_val >= 18'(n_eff));
    dup     = !seq_oor && d_ge_n && ((18'(range_eff) - d_val) <= 18'(n_eff));
    wraps   = ((18'(base_q) + 18'(n_eff) - 18'd1) >= 18'(range_eff)) && (seq_q >= base_q);
    off_sel = wraps ? offp_q : offc_q;
    is_base = (seq_q == base_q);
  end

  always_comb begin
    walk_cont = (walked_q < n_eff) && marks_q[i_q];
    nb_full   = 17'(base_q) + 17'd1;
    next_base = (nb_full == range_eff) ? '0 : nb_full[SEQ_W-1:0];
    end_new   = 18'(next_base) + 18'(n_eff) - 18'd1;
    end_zero  = (end_new == '0) || (end_new == 18'(range_eff));
    newc_sum  = (SW+1)'(cur_q) + (SW+1)'(rs_q);
    newc      = (newc_sum >= (SW+1)'(slots_eff)) ?
                SW'(newc_sum - (SW+1)'(slots_eff)) : SW'(newc_sum);
    ip1       = (SW+1)'(i_q) + (SW+1)'(1);
    i_next    = (ip1 == (SW+1)'(slots_eff)) ? '0 : SW'(ip1);
  end

  always_comb begin
    div_divisor = DIV_W'(slots_eff);
    unique case (cmd_i.div_sel)
      DIV_BASE: begin
        div_dividend = DIV_W'(window_base_q);
        div_divisor  = DIV_W'(range_eff);
      end
      DIV_OFF:  div_dividend = DIV_W'(off_sel);
      DIV_SLOT: div_dividend = DIV_W'(seq_q) + div_rem;
      DIV_CUR:  div_dividend = DIV_W'(offc_q);
      DIV_RS:   div_dividend = DIV_W'(range_eff);
      default:  div_dividend = '0;
    endcase
  end

  srw_div #(
    .W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign emit_any = cmd_i.emit_verdict || cmd_i.emit_accept ||
                    (cmd_i.walk_step && (!walk_cont || pend_v_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q         <= WIN_W'(8);
      range_cfg_q   <= RANGE_W'(32);
      slots_cfg_q   <= WIN_W'(16);
      marks_q       <= '0;
      window_base_q <= '0;
      offc_q        <= '0;
      offp_q        <= '0;
      pend_v_q      <= 1'b0;
      walked_q      <= '0;
      i_q           <= '0;
      sel_q         <= DIV_BASE;
      strobe_q      <= 1'b0;
    end else begin
      strobe_q <= emit_any;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_WINDOW: win_q       <= cfg_data_i[WIN_W-1:0];
          CFG_RANGE:  range_cfg_q <= cfg_data_i[RANGE_W-1:0];
          CFG_SLOTS:  slots_cfg_q <= cfg_data_i[WIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.div_start) sel_q <= cmd_i.div_sel;
      if (cmd_i.emit_accept) begin
        marks_q[slot_idx_q] <= 1'b1;
        i_q                 <= slot_idx_q;
        walked_q            <= '0;
        pend_v_q            <= 1'b0;
      end
      if (cmd_i.walk_step && walk_cont) begin
        marks_q[i_q]  <= 1'b0;
        pend_v_q      <= 1'b1;
        walked_q      <= walked_q + WIN_W'(1);
        i_q           <= i_next;
        window_base_q <= next_base;
        if (end_zero) begin
          offp_q <= cur_q;
          offc_q <= newc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_seq) seq_q <= seq_number_i;
    if (div_done) begin
      unique case (sel_q)
        DIV_BASE: base_q     <= div_rem[SEQ_W-1:0];
        DIV_SLOT: slot_idx_q <= div_rem[SW-1:0];
        DIV_CUR:  cur_q      <= div_rem[SW-1:0];
        DIV_RS:   rs_q       <= div_rem[SW-1:0];
        default: ;
      endcase
    end
    if (cmd_i.walk_step && walk_cont) begin
      pend_slot_q <= i_q;
      pend_seq_q  <= base_q;
      base_q      <= next_base;
      if (end_zero) cur_q <= newc;
    end

    if (cmd_i.emit_verdict) begin
      kind_q     <= dup ? KIND_DUP : KIND_OOW;
      slot_out_q <= '0;
      dseq_q     <= seq_q;
      ack_q      <= dup;
      last_q     <= 1'b1;
    end else if (cmd_i.emit_accept) begin
      kind_q     <= KIND_ACCEPT;
      slot_out_q <= SLOT_OUT_W'(slot_idx_q);
      dseq_q     <= seq_q;
      ack_q      <= 1'b1;
      last_q     <= !is_base;
    end else if (cmd_i.walk_step) begin
      kind_q     <= KIND_DELIVER;
      slot_out_q <= SLOT_OUT_W'(pend_slot_q);
      dseq_q     <= pend_seq_q;
      ack_q      <= 1'b0;
      last_q     <= !walk_cont;
    end
  end

  assign stat_o.div_done  = div_done;
  assign stat_o.reject    = seq_oor || d_ge_n;
  assign stat_o.is_base   = is_base;
  assign stat_o.walk_cont = walk_cont;

  assign result_strobe_o = strobe_q;
  assign kind_o          = kind_q;
  assign slot_o          = slot_out_q;
  assign delivered_seq_o = dseq_q;
  assign ack_req_o       = ack_q;
  assign last_o          = last_q;

endmodule

// ===== rtl/core/selective_repeat_receive_window_core.sv =====
// Top level of the selective repeat receive window: controller plus datapath.
// A packet number is taken when start_i is high and busy_o is low. Each result is shown for
// one cycle on result_strobe_o, and the receiver cannot stall it; last_o marks the final
// result of a packet. Every modulo step runs on one shared 17-bit shift-subtract remainder
// unit. A duplicate or out-of-window packet uses it for the window base only, an accepted
// packet that is not at the window base also for its offset and slot, and a packet at the
// base also for the current offset and the range remainder before a walk that delivers its
// packets, the deliveries coming out on consecutive cycles. The final result shows in the
// first cycle with busy_o low. Configuration writes are taken in any cycle and must be made
// only while the block is idle.
module selective_repeat_receive_window_core #(
  parameter int BUF_SLOTS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [srw_pkg::SEQ_W-1:0]         seq_number_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [srw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [srw_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                              result_strobe_o,
  output logic [1:0]                        kind_o,
  output logic [srw_pkg::SLOT_OUT_W-1:0]    slot_o,
  output logic [srw_pkg::SEQ_W-1:0]         delivered_seq_o,
  output logic                              ack_req_o,
  output logic                              last_o
);

  import srw_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  srw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  srw_dp #(
    .BUF_SLOTS (BUF_SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .seq_number_i    (seq_number_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_strobe_o (result_strobe_o),
    .kind_o          (kind_o),
    .slot_o          (slot_o),
    .delivered_seq_o (delivered_seq_o),
    .ack_req_o       (ack_req_o),
    .last_o          (last_o)
  );

endmodule

// ===== rtl/core/srw_checker.sv =====
// Port-level assertions for the receive window core and the bind that attaches them.
module srw_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              result_strobe_o,
  input logic [1:0]                        kind_o,
  input logic [srw_pkg::SLOT_OUT_W-1:0]    slot_o,
  input logic                              ack_req_o,
  input logic                              last_o
);

  import srw_pkg::*;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("transfer accepted but block not busy");

  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && (kind_o == KIND_DUP || kind_o == KIND_OOW) |-> last_o)
    else $error("duplicate or out-of-window verdict not final");

  a_oow_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && kind_o == KIND_OOW |-> !ack_req_o && slot_o == '0)
    else $error("out-of-window verdict with ack or slot");

  a_deliver_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && kind_o == KIND_DELIVER && !last_o |=>
    result_strobe_o && kind_o == KIND_DELIVER)
    else $error("delivery run broken");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && last_o |-> !busy_o)
    else $error("final result while still busy");

endmodule

bind selective_repeat_receive_window_core srw_checker u_srw_checker (.*);
